### rtl/ray_box_slab_intersect_core_defines.svh
// assertion macros for the ray box slab intersect core
`ifndef RAY_BOX_SLAB_INTERSECT_CORE_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECT_CORE_DEFINES_SVH

// condition implies consequence in the same cycle
`define RBSI_ASSERT_HOLDS(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rbsi check failed");

// condition never seen
`define RBSI_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rbsi forbidden condition");

`endif

### rtl/rbsi_pkg.sv
// shared types and constants for the ray box slab intersect core
`timescale 1ns / 1ps
`default_nettype none
package rbsi_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int NUM_AXES    = 3;
  localparam int NUM_FACES   = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int FACE_W      = 3;
  localparam int SLAB_STAGES = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } cfg_reg_t;

  localparam logic [FACE_W-1:0] FACE_MIN_X = 3'd0;
  localparam logic [FACE_W-1:0] FACE_MIN_Y = 3'd1;
  localparam logic [FACE_W-1:0] FACE_MIN_Z = 3'd2;
  localparam logic [FACE_W-1:0] FACE_MAX_X = 3'd3;
  localparam logic [FACE_W-1:0] FACE_MAX_Y = 3'd4;
  localparam logic [FACE_W-1:0] FACE_MAX_Z = 3'd5;

  typedef struct packed {
    logic zero;
    logic in_slab;
    logic dneg;
    logic qneg_min;
    logic qneg_max;
  } axis_flag_t;

endpackage
`default_nettype wire

### rtl/rbsi_div_lane.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module rbsi_div_lane #(
  parameter int W = 32
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [W-1:0]                      num,
  input  wire logic [W-1:0]                      den,
  output logic      [W+rbsi_pkg::FRAC_BITS-1:0]  quo
);
  import rbsi_pkg::*;

  localparam int NW = W + FRAC_BITS;

  logic [W-1:0]  rem_r [NW];
  logic [W-1:0]  den_r [NW];
  logic [NW-1:0] nq_r  [NW];

  for (genvar s = 0; s < NW; s++) begin : g_step
    logic [W-1:0]  rem_in;
    logic [W-1:0]  den_in;
    logic [NW-1:0] nq_in;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic [W-1:0]  rem_nxt;
    logic [NW-1:0] nq_nxt;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den;
      assign nq_in  = {num, {FRAC_BITS{1'b0}}};
    end else begin : g_rest
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign nq_in  = nq_r[s-1];
    end

    assign trial = {rem_in, nq_in[NW-1]};
    assign diff  = trial - {1'b0, den_in};

    always_comb begin
      if (trial >= {1'b0, den_in}) begin
        rem_nxt = diff[W-1:0];
        nq_nxt  = {nq_in[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        nq_nxt  = {nq_in[NW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        den_r[s] <= den_in;
        nq_r[s]  <= nq_nxt;
      end
    end
  end

  assign quo = nq_r[NW-1];

endmodule
`default_nettype wire

### rtl/rbsi_slab.sv
// slab intervals, interval intersection and entry saturation
`timescale 1ns / 1ps
`default_nettype none
module rbsi_slab #(
  parameter int W = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             en,
  input  wire logic                             v_in,
  input  wire logic [W+rbsi_pkg::FRAC_BITS-1:0] qmin [rbsi_pkg::NUM_AXES],
  input  wire logic [W+rbsi_pkg::FRAC_BITS-1:0] qmax [rbsi_pkg::NUM_AXES],
  input  wire rbsi_pkg::axis_flag_t             flags [rbsi_pkg::NUM_AXES],
  output logic                                  v_out,
  output logic                                  hit_out,
  output logic signed [W-1:0]                   entry_out
);
  import rbsi_pkg::*;

  localparam int NW = W + FRAC_BITS;
  localparam int TW = NW + 2;
  localparam logic signed [TW-1:0] T_INF    = {2'b01, {NW{1'b0}}};
  localparam logic signed [TW-1:0] T_SAT_HI = TW'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [TW-1:0] T_SAT_LO = -T_SAT_HI - TW'(1);

  // per axis interval
  logic                 va_r;
  logic signed [TW-1:0] lo_a_r [NUM_AXES];
  logic signed [TW-1:0] hi_a_r [NUM_AXES];
  logic                 miss_a_r [NUM_AXES];
  logic signed [TW-1:0] lo_a_nxt [NUM_AXES];
  logic signed [TW-1:0] hi_a_nxt [NUM_AXES];
  logic                 miss_a_nxt [NUM_AXES];

  always_comb begin
    logic signed [TW-1:0] tmin;
    logic signed [TW-1:0] tmax;
    for (int a = 0; a < NUM_AXES; a++) begin
      tmin = $signed(TW'(qmin[a]));
      tmax = $signed(TW'(qmax[a]));
      if (flags[a].qneg_min) tmin = -tmin;
      if (flags[a].qneg_max) tmax = -tmax;
      if (flags[a].zero) begin
        lo_a_nxt[a] = -T_INF;
        hi_a_nxt[a] = T_INF;
      end else if (flags[a].dneg) begin
        lo_a_nxt[a] = tmax;
        hi_a_nxt[a] = tmin;
      end else begin
        lo_a_nxt[a] = tmin;
        hi_a_nxt[a] = tmax;
      end
      miss_a_nxt[a] = flags[a].zero && !flags[a].in_slab;
    end
  end

  // x and y combined
  logic                 vb_r;
  logic signed [TW-1:0] lo_b_r, hi_b_r, lo_z_r, hi_z_r;
  logic                 miss_b_r;

  // z combined
  logic                 vc_r;
  logic signed [TW-1:0] lo_c_r;
  logic                 hit_c_r;

  // entry saturation
  logic                 vd_r;
  logic                 hit_d_r;
  logic signed [W-1:0]  entry_d_r;
  logic signed [W-1:0]  entry_d_nxt;

  always_comb begin
    if (lo_c_r > T_SAT_HI) begin
      entry_d_nxt = T_SAT_HI[W-1:0];
    end else if (lo_c_r < T_SAT_LO) begin
      entry_d_nxt = T_SAT_LO[W-1:0];
    end else begin
      entry_d_nxt = lo_c_r[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      va_r <= v_in;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_a_r   <= lo_a_nxt;
      hi_a_r   <= hi_a_nxt;
      miss_a_r <= miss_a_nxt;

      miss_b_r <= miss_a_r[0] || miss_a_r[1] || miss_a_r[2] ||
                  (lo_a_r[0] > hi_a_r[1]) || (lo_a_r[1] > hi_a_r[0]);
      lo_b_r   <= (lo_a_r[1] > lo_a_r[0]) ? lo_a_r[1] : lo_a_r[0];
      hi_b_r   <= (hi_a_r[1] < hi_a_r[0]) ? hi_a_r[1] : hi_a_r[0];
      lo_z_r   <= lo_a_r[2];
      hi_z_r   <= hi_a_r[2];

      hit_c_r  <= !(miss_b_r || (lo_b_r > hi_z_r) || (lo_z_r > hi_b_r));
      lo_c_r   <= (lo_z_r > lo_b_r) ? lo_z_r : lo_b_r;

      hit_d_r   <= hit_c_r;
      entry_d_r <= entry_d_nxt;
    end
  end

  assign v_out     = vd_r;
  assign hit_out   = hit_d_r;
  assign entry_out = entry_d_r;

endmodule
`default_nettype wire

### rtl/rbsi_face.sv
// entry point, plane distances and nearest face selection
`timescale 1ns / 1ps
`default_nettype none
module rbsi_face #(
  parameter int W = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          v_in,
  input  wire logic                          hit_in,
  input  wire logic signed [W-1:0]           entry_in,
  input  wire logic signed [W-1:0]           o_in    [rbsi_pkg::NUM_AXES],
  input  wire logic signed [W-1:0]           d_in    [rbsi_pkg::NUM_AXES],
  input  wire logic signed [W-1:0]           box_min [rbsi_pkg::NUM_AXES],
  input  wire logic signed [W-1:0]           box_max [rbsi_pkg::NUM_AXES],
  output logic                               v_out,
  output logic                               hit_out,
  output logic signed [W-1:0]                entry_out,
  output logic [rbsi_pkg::FACE_W-1:0]        face_out
);
  import rbsi_pkg::*;

  localparam int MW = 2 * W;
  localparam int QW = MW - FRAC_BITS;
  localparam int PW = QW + 1;
  localparam int DW = PW + 1;
  localparam logic signed [W-1:0] ENTRY_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [MW-1:0] RND_BIAS = MW'({FRAC_BITS{1'b1}});

  logic                v_r [6];
  logic                hit_r [6];
  logic signed [W-1:0] entry_r [6];
  logic signed [W-1:0] o1_r [NUM_AXES];
  logic signed [W-1:0] o2_r [NUM_AXES];

  logic signed [MW-1:0] prod_r [NUM_AXES];
  logic signed [QW-1:0] q_r [NUM_AXES];
  logic signed [PW-1:0] p_r [NUM_AXES];
  logic signed [DW-1:0] dist_r [NUM_FACES];
  logic [DW-1:0]        mag_r [NUM_FACES];
  logic [DW-1:0]        best_r [NUM_AXES];
  logic [FACE_W-1:0]    bidx_r [NUM_AXES];

  logic                 out_valid_r, out_hit_r;
  logic signed [W-1:0]  out_entry_r;
  logic [FACE_W-1:0]    out_face_r;

  logic signed [QW-1:0] q_nxt [NUM_AXES];
  logic [DW-1:0]        best_nxt [NUM_AXES];
  logic [FACE_W-1:0]    bidx_nxt [NUM_AXES];
  logic [FACE_W-1:0]    face_nxt;

  always_comb begin
    logic signed [MW-1:0] biased;
    for (int a = 0; a < NUM_AXES; a++) begin
      biased   = prod_r[a] + (prod_r[a][MW-1] ? RND_BIAS : '0);
      q_nxt[a] = biased[MW-1:FRAC_BITS];
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      if (mag_r[2*k+1] < mag_r[2*k]) begin
        best_nxt[k] = mag_r[2*k+1];
        bidx_nxt[k] = FACE_W'(2*k+1);
      end else begin
        best_nxt[k] = mag_r[2*k];
        bidx_nxt[k] = FACE_W'(2*k);
      end
    end
  end

  always_comb begin
    logic [DW-1:0] bv;
    if (best_r[1] < best_r[0]) begin
      bv       = best_r[1];
      face_nxt = bidx_r[1];
    end else begin
      bv       = best_r[0];
      face_nxt = bidx_r[0];
    end
    if (best_r[2] < bv) face_nxt = bidx_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 6; s++) v_r[s] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= v_in;
      for (int s = 1; s < 6; s++) v_r[s] <= v_r[s-1];
      out_valid_r <= v_r[5];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r[0]   <= hit_in;
      entry_r[0] <= entry_in;
      for (int s = 1; s < 6; s++) begin
        hit_r[s]   <= hit_r[s-1];
        entry_r[s] <= entry_r[s-1];
      end
      o1_r <= o_in;
      o2_r <= o1_r;
      for (int a = 0; a < NUM_AXES; a++) begin
        prod_r[a] <= MW'(entry_in) * MW'(d_in[a]);
        q_r[a]    <= q_nxt[a];
        p_r[a]    <= PW'(o2_r[a]) + PW'(q_r[a]);
        dist_r[a]            <= DW'(box_min[a]) - DW'(p_r[a]);
        dist_r[a + NUM_AXES] <= DW'(box_max[a]) - DW'(p_r[a]);
      end
      for (int f = 0; f < NUM_FACES; f++) begin
        mag_r[f] <= dist_r[f][DW-1] ? DW'(-dist_r[f]) : DW'(dist_r[f]);
      end
      best_r <= best_nxt;
      bidx_r <= bidx_nxt;
      out_hit_r <= hit_r[5];
      if (hit_r[5]) begin
        out_entry_r <= entry_r[5];
        out_face_r  <= face_nxt;
      end else begin
        out_entry_r <= ENTRY_MAX;
        out_face_r  <= FACE_MIN_X;
      end
    end
  end

  assign v_out     = out_valid_r;
  assign hit_out   = out_hit_r;
  assign entry_out = out_entry_r;
  assign face_out  = out_face_r;

endmodule
`default_nettype wire

### rtl/ray_box_slab_intersect_core.sv
// ray against axis-aligned box slab test, top level
// one ray per cycle unless the result side stalls; the divider runs one quotient bit per stage
// across COORD_WIDTH + 16 stages in six parallel lanes
// a stall on the result side while a result is valid freezes the whole pipeline; no bubbles are added
// synchronous active-low reset clears valid bits and zeroes the box registers
`timescale 1ns / 1ps
`default_nettype none
`include "ray_box_slab_intersect_core_defines.svh"
module ray_box_slab_intersect_core #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [rbsi_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [COORD_WIDTH-1:0]                cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [COORD_WIDTH-1:0]         in_origin_x,
  input  wire logic signed [COORD_WIDTH-1:0]         in_origin_y,
  input  wire logic signed [COORD_WIDTH-1:0]         in_origin_z,
  input  wire logic signed [COORD_WIDTH-1:0]         in_dir_x,
  input  wire logic signed [COORD_WIDTH-1:0]         in_dir_y,
  input  wire logic signed [COORD_WIDTH-1:0]         in_dir_z,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       out_hit,
  output logic signed [COORD_WIDTH-1:0]              out_entry_distance,
  output logic [rbsi_pkg::FACE_W-1:0]                out_face
);
  import rbsi_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int NW = W + FRAC_BITS;
  localparam int OD = NW + SLAB_STAGES;
  localparam logic signed [W-1:0] ENTRY_MAX = {1'b0, {(W-1){1'b1}}};

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // box registers
  logic signed [W-1:0] box_min_r [NUM_AXES];
  logic signed [W-1:0] box_max_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        box_min_r[a] <= '0;
        box_max_r[a] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BOX_MIN_X: box_min_r[0] <= cfg_data;
        REG_BOX_MIN_Y: box_min_r[1] <= cfg_data;
        REG_BOX_MIN_Z: box_min_r[2] <= cfg_data;
        REG_BOX_MAX_X: box_max_r[0] <= cfg_data;
        REG_BOX_MAX_Y: box_max_r[1] <= cfg_data;
        REG_BOX_MAX_Z: box_max_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [W-1:0] o_in [NUM_AXES];
  logic signed [W-1:0] d_in [NUM_AXES];
  assign o_in[0] = in_origin_x;
  assign o_in[1] = in_origin_y;
  assign o_in[2] = in_origin_z;
  assign d_in[0] = in_dir_x;
  assign d_in[1] = in_dir_y;
  assign d_in[2] = in_dir_z;

  // plane offsets
  logic                v1_r;
  logic signed [W-1:0] o1_r [NUM_AXES];
  logic signed [W-1:0] d1_r [NUM_AXES];
  logic signed [W:0]   dmin1_r [NUM_AXES];
  logic signed [W:0]   dmax1_r [NUM_AXES];
  logic                zero1_r [NUM_AXES];
  logic                inside1_r [NUM_AXES];

  // magnitudes and signs
  logic                v2_r;
  logic signed [W-1:0] o2_r [NUM_AXES];
  logic signed [W-1:0] d2_r [NUM_AXES];
  logic [W-1:0]        mmin2_r [NUM_AXES];
  logic [W-1:0]        mmax2_r [NUM_AXES];
  logic [W-1:0]        dmag2_r [NUM_AXES];
  axis_flag_t          flags2_r [NUM_AXES];

  logic [W-1:0]        mmin_nxt [NUM_AXES];
  logic [W-1:0]        mmax_nxt [NUM_AXES];
  logic [W-1:0]        dmag_nxt [NUM_AXES];
  axis_flag_t          flags_nxt [NUM_AXES];

  always_comb begin
    logic signed [W:0] nmin;
    logic signed [W:0] nmax;
    logic signed [W:0] dw;
    for (int a = 0; a < NUM_AXES; a++) begin
      nmin = -dmin1_r[a];
      nmax = -dmax1_r[a];
      dw   = (W+1)'(d1_r[a]);
      mmin_nxt[a] = dmin1_r[a][W] ? nmin[W-1:0] : dmin1_r[a][W-1:0];
      mmax_nxt[a] = dmax1_r[a][W] ? nmax[W-1:0] : dmax1_r[a][W-1:0];
      dw          = d1_r[a][W-1] ? -dw : dw;
      dmag_nxt[a] = dw[W-1:0];
      flags_nxt[a].zero     = zero1_r[a];
      flags_nxt[a].in_slab  = inside1_r[a];
      flags_nxt[a].dneg     = d1_r[a][W-1];
      flags_nxt[a].qneg_min = dmin1_r[a][W] ^ d1_r[a][W-1];
      flags_nxt[a].qneg_max = dmax1_r[a][W] ^ d1_r[a][W-1];
    end
  end

  // sideband lines beside the divider
  logic                sb_v_r [NW];
  axis_flag_t          sb_f_r [NW][NUM_AXES];
  logic signed [W-1:0] sb_o_r [OD][NUM_AXES];
  logic signed [W-1:0] sb_d_r [OD][NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      for (int s = 0; s < NW; s++) sb_v_r[s] <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      sb_v_r[0] <= v2_r;
      for (int s = 1; s < NW; s++) sb_v_r[s] <= sb_v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        o1_r[a]      <= o_in[a];
        d1_r[a]      <= d_in[a];
        dmin1_r[a]   <= (W+1)'(box_min_r[a]) - (W+1)'(o_in[a]);
        dmax1_r[a]   <= (W+1)'(box_max_r[a]) - (W+1)'(o_in[a]);
        zero1_r[a]   <= (d_in[a] == '0);
        inside1_r[a] <= (o_in[a] >= box_min_r[a]) && (o_in[a] <= box_max_r[a]);
      end
      o2_r     <= o1_r;
      d2_r     <= d1_r;
      mmin2_r  <= mmin_nxt;
      mmax2_r  <= mmax_nxt;
      dmag2_r  <= dmag_nxt;
      flags2_r <= flags_nxt;
      sb_f_r[0] <= flags2_r;
      sb_o_r[0] <= o2_r;
      sb_d_r[0] <= d2_r;
      for (int s = 1; s < NW; s++) sb_f_r[s] <= sb_f_r[s-1];
      for (int s = 1; s < OD; s++) begin
        sb_o_r[s] <= sb_o_r[s-1];
        sb_d_r[s] <= sb_d_r[s-1];
      end
    end
  end

  // dividers
  logic [NW-1:0] qmin [NUM_AXES];
  logic [NW-1:0] qmax [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    rbsi_div_lane #(.W(W)) u_div_min (
      .clk (clk),
      .en  (adv),
      .num (mmin2_r[a]),
      .den (dmag2_r[a]),
      .quo (qmin[a])
    );
    rbsi_div_lane #(.W(W)) u_div_max (
      .clk (clk),
      .en  (adv),
      .num (mmax2_r[a]),
      .den (dmag2_r[a]),
      .quo (qmax[a])
    );
  end

  logic                slab_v, slab_hit;
  logic signed [W-1:0] slab_entry;

  rbsi_slab #(.W(W)) u_slab (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .v_in      (sb_v_r[NW-1]),
    .qmin      (qmin),
    .qmax      (qmax),
    .flags     (sb_f_r[NW-1]),
    .v_out     (slab_v),
    .hit_out   (slab_hit),
    .entry_out (slab_entry)
  );

  rbsi_face #(.W(W)) u_face (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .v_in      (slab_v),
    .hit_in    (slab_hit),
    .entry_in  (slab_entry),
    .o_in      (sb_o_r[OD-1]),
    .d_in      (sb_d_r[OD-1]),
    .box_min   (box_min_r),
    .box_max   (box_max_r),
    .v_out     (out_valid),
    .hit_out   (out_hit),
    .entry_out (out_entry_distance),
    .face_out  (out_face)
  );

  `RBSI_ASSERT_HOLDS(a_miss_word, out_valid && !out_hit, (out_entry_distance == ENTRY_MAX) && (out_face == FACE_MIN_X))
  `RBSI_ASSERT_HOLDS(a_face_code, out_valid && out_hit, out_face <= FACE_MAX_Z)
  `RBSI_ASSERT_NEVER(a_stall_empty, in_stall && !out_valid)

endmodule
`default_nettype wire
